/* hw/rtl/ipv4_frame_eligibility_check_assert.svh */
// Assertion macros for the checker file of the IPv4 frame eligibility check.
// No dependencies; include by bare file name.
`ifndef IPV4_FRAME_ELIGIBILITY_CHECK_ASSERT_SVH
`define IPV4_FRAME_ELIGIBILITY_CHECK_ASSERT_SVH

// Clocked property, disabled while reset is asserted.
`define IFEC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define IFEC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/ifec_pkg.sv */
// Package for the IPv4 frame eligibility check: reason codes, frame offsets
// and limits. No dependencies.
`default_nettype none

package ifec_pkg;

    typedef logic [3:0] reason_t;
    typedef logic [5:0] pos_t;
    typedef logic [6:0] frame_len_t;

    localparam reason_t REASON_OK         = 4'd0;
    localparam reason_t REASON_META       = 4'd1;
    localparam reason_t REASON_SHORT_IP   = 4'd2;
    localparam reason_t REASON_ETHERTYPE  = 4'd3;
    localparam reason_t REASON_VERSION    = 4'd4;
    localparam reason_t REASON_IHL        = 4'd5;
    localparam reason_t REASON_TOO_LONG   = 4'd6;
    localparam reason_t REASON_CHECKSUM   = 4'd7;
    localparam reason_t REASON_TOO_SMALL  = 4'd8;
    localparam reason_t REASON_FRAGMENT   = 4'd9;
    localparam reason_t REASON_PROTOCOL   = 4'd10;
    localparam reason_t REASON_SHORT_L4   = 4'd11;

    // Byte offsets within the frame
    localparam pos_t POS_ETYPE_HI  = 6'd12;
    localparam pos_t POS_ETYPE_LO  = 6'd13;
    localparam pos_t POS_VER_IHL   = 6'd14;
    localparam pos_t POS_TLEN_HI   = 6'd16;
    localparam pos_t POS_TLEN_LO   = 6'd17;
    localparam pos_t POS_FRAG_HI   = 6'd20;
    localparam pos_t POS_FRAG_LO   = 6'd21;
    localparam pos_t POS_PROTO     = 6'd23;
    localparam pos_t POS_IP_FIRST  = 6'd14;
    localparam pos_t POS_IP_LAST   = 6'd33;
    localparam pos_t POS_MAX       = 6'd63;

    localparam frame_len_t MIN_IP_FRAME   = 7'd34;
    localparam frame_len_t TCP_FRAME      = 7'd54;
    localparam frame_len_t SMALL_L4_FRAME = 7'd42;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [3:0]  IP_VERSION_4   = 4'd4;
    localparam logic [3:0]  IHL_NO_OPTIONS = 4'd5;
    localparam logic [15:0] TLEN_MAX       = 16'd65495;
    localparam logic [15:0] TLEN_MIN       = 16'd20;
    localparam logic [15:0] FRAG_MASK      = 16'hBFFF;
    localparam logic [15:0] CSUM_GOOD      = 16'hFFFF;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

endpackage

`default_nettype wire

/* hw/rtl/ipv4_frame_eligibility_check.sv */
// IPv4 frame eligibility check, top level (single module).
// Depends on ifec_pkg.
//
// Takes an Ethernet frame one byte per item, destination MAC first, and
// gives one verdict per frame, registered after its last byte leaves the
// input register: eligible = 1 for a plain IPv4 frame with TCP, UDP or
// ICMP, else 0 with the first failed check in reason. Bytes are taken one
// per cycle with no gaps; the input stalls only when a verdict sits in the
// result register and m_ready is low while the next last byte wants to
// leave the input register. The header checksum is kept as a running
// 16-bit ones'-complement sum with end-around carry, one add per header word.
`default_nettype none

module ipv4_frame_eligibility_check
    import ifec_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_last_byte,
    input  wire logic       s_meta_is_ipv4,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_eligible,
    output logic [3:0]      m_reason
);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       in_meta_reg;

    // Frame state
    pos_t        pos_reg;
    logic        meta_reg;
    logic [15:0] etype_reg;
    logic [7:0]  ver_ihl_reg;
    logic [15:0] tlen_reg;
    logic [15:0] frag_reg;
    logic [7:0]  proto_reg;
    logic [15:0] csum_reg;
    logic [7:0]  pend_reg;

    // Result register
    logic    out_valid_reg;
    logic    out_elig_reg;
    reason_t out_reason_reg;

    logic        out_free;
    logic        advance;
    logic        meta_next;
    logic [15:0] etype_next;
    logic [7:0]  ver_ihl_next;
    logic [15:0] tlen_next;
    logic [15:0] frag_next;
    logic [7:0]  proto_next;
    logic [15:0] csum_next;
    logic [7:0]  pend_next;
    logic [16:0] csum_wide;
    logic        in_ip_hdr;
    frame_len_t  frame_len;
    pos_t        pos_next;
    reason_t     reason_next;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;

    // Field capture for the byte in the input register
    always_comb begin
        meta_next    = (pos_reg == '0) ? in_meta_reg : meta_reg;
        etype_next   = etype_reg;
        ver_ihl_next = ver_ihl_reg;
        tlen_next    = tlen_reg;
        frag_next    = frag_reg;
        proto_next   = proto_reg;
        if (pos_reg == POS_ETYPE_HI) etype_next = {in_byte_reg, 8'h00};
        if (pos_reg == POS_ETYPE_LO) etype_next = {etype_reg[15:8], in_byte_reg};
        if (pos_reg == POS_VER_IHL)  ver_ihl_next = in_byte_reg;
        if (pos_reg == POS_TLEN_HI)  tlen_next = {in_byte_reg, 8'h00};
        if (pos_reg == POS_TLEN_LO)  tlen_next = {tlen_reg[15:8], in_byte_reg};
        if (pos_reg == POS_FRAG_HI)  frag_next = {in_byte_reg, 8'h00};
        if (pos_reg == POS_FRAG_LO)  frag_next = {frag_reg[15:8], in_byte_reg};
        if (pos_reg == POS_PROTO)    proto_next = in_byte_reg;
    end

    // Header words start on even offsets (header begins at 14)
    assign in_ip_hdr = (pos_reg >= POS_IP_FIRST) && (pos_reg <= POS_IP_LAST);
    assign csum_wide = {1'b0, csum_reg} + {1'b0, pend_reg, in_byte_reg};

    always_comb begin
        pend_next = pend_reg;
        csum_next = csum_reg;
        if (in_ip_hdr) begin
            if (!pos_reg[0]) begin
                pend_next = in_byte_reg;
            end else begin
                // end-around carry; matches a twice-folded full sum
                csum_next = csum_wide[15:0] + {15'd0, csum_wide[16]};
            end
        end
    end

    assign pos_next  = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 6'd1;
    assign frame_len = {1'b0, pos_reg} + 7'd1;

    always_comb begin
        priority if (!meta_next) begin
            reason_next = REASON_META;
        end else if (frame_len < MIN_IP_FRAME) begin
            reason_next = REASON_SHORT_IP;
        end else if (etype_next != ETHERTYPE_IPV4) begin
            reason_next = REASON_ETHERTYPE;
        end else if (ver_ihl_next[7:4] != IP_VERSION_4) begin
            reason_next = REASON_VERSION;
        end else if (ver_ihl_next[3:0] != IHL_NO_OPTIONS) begin
            reason_next = REASON_IHL;
        end else if (tlen_next > TLEN_MAX) begin
            reason_next = REASON_TOO_LONG;
        end else if (csum_next != CSUM_GOOD) begin
            reason_next = REASON_CHECKSUM;
        end else if (tlen_next < TLEN_MIN) begin
            reason_next = REASON_TOO_SMALL;
        end else if ((frag_next & FRAG_MASK) != '0) begin
            reason_next = REASON_FRAGMENT;
        end else if (proto_next == PROTO_TCP) begin
            reason_next = (frame_len < TCP_FRAME) ? REASON_SHORT_L4 : REASON_OK;
        end else if (proto_next == PROTO_UDP || proto_next == PROTO_ICMP) begin
            reason_next = (frame_len < SMALL_L4_FRAME) ? REASON_SHORT_L4 : REASON_OK;
        end else begin
            reason_next = REASON_PROTOCOL;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            pos_reg       <= '0;
            meta_reg      <= 1'b0;
            csum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                if (in_last_reg) begin
                    pos_reg  <= '0;
                    meta_reg <= 1'b0;
                    csum_reg <= '0;
                end else begin
                    pos_reg  <= pos_next;
                    meta_reg <= meta_next;
                    csum_reg <= csum_next;
                end
            end
            if (advance && in_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload; fields are always rewritten before a frame long enough to read them
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
            in_meta_reg <= s_meta_is_ipv4;
        end
        if (advance) begin
            etype_reg   <= etype_next;
            ver_ihl_reg <= ver_ihl_next;
            tlen_reg    <= tlen_next;
            frag_reg    <= frag_next;
            proto_reg   <= proto_next;
            pend_reg    <= pend_next;
        end
        if (advance && in_last_reg) begin
            out_reason_reg <= reason_next;
            out_elig_reg   <= (reason_next == REASON_OK);
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_eligible = out_elig_reg;
    assign m_reason   = out_reason_reg;

endmodule

`default_nettype wire

/* hw/rtl/ifec_checker.sv */
// Port-level checker for the IPv4 frame eligibility check, bound to the top level.
// Depends on ifec_pkg and ipv4_frame_eligibility_check_assert.svh.
`default_nettype none
`include "ipv4_frame_eligibility_check_assert.svh"

module ifec_checker
    import ifec_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic [7:0] s_data_byte,
    input wire logic       s_last_byte,
    input wire logic       s_meta_is_ipv4,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_eligible,
    input wire logic [3:0] m_reason
);

    logic in_stall;
    logic out_stall;
    assign in_stall  = s_valid && !s_ready;
    assign out_stall = m_valid && !m_ready;

    `IFEC_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_valid,
        "result valid after reset")
    `IFEC_ASSERT(a_elig_matches_reason, aclk, aresetn,
        m_valid |-> (m_eligible == (m_reason == REASON_OK)),
        "eligible disagrees with reason")
    `IFEC_ASSERT(a_reason_range, aclk, aresetn, m_valid |-> (m_reason <= REASON_SHORT_L4),
        "reason code out of range")
    `IFEC_ASSERT(a_out_hold, aclk, aresetn,
        out_stall |=> (m_valid && $stable(m_reason) && $stable(m_eligible)),
        "stalled result changed")
    `IFEC_ASSERT(a_in_hold, aclk, aresetn,
        in_stall |=> (s_valid && $stable(s_data_byte) && $stable(s_last_byte)
                      && $stable(s_meta_is_ipv4)),
        "stalled input item changed")

endmodule

bind ipv4_frame_eligibility_check ifec_checker u_ifec_checker (.*);

`default_nettype wire
